>>> hdl/rsi_pkg.sv
`timescale 1ns / 1ps
package rsi_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int COORD_W = 31;
  localparam int DIR_W   = 18;
  localparam int RAD_W   = 30;
  localparam int DIST_W  = 32;
  localparam int CNT_W   = 2;
  localparam int REL_W   = COORD_W + 1;
  localparam int DOT_W   = REL_W + DIR_W + 2;
  localparam int SQ_W    = 64;
  localparam int ROOT_W  = SQ_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int DIFF_W  = DIST_W + 2;

  localparam int SQRT_STEPS_PER_STAGE = 2;
  localparam int SQRT_STAGES          = ROOT_W / SQRT_STEPS_PER_STAGE;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_INNER_R  = 3'd3,
    REG_OUTER_R  = 3'd4
  } cfg_reg_t;

  localparam logic signed [COORD_W-1:0] CENTER_X_RST = '0;
  localparam logic signed [COORD_W-1:0] CENTER_Y_RST = -31'sd65536000;
  localparam logic signed [COORD_W-1:0] CENTER_Z_RST = '0;
  localparam logic [RAD_W-1:0]          INNER_R_RST  = 30'd68812800;
  localparam logic [RAD_W-1:0]          OUTER_R_RST  = 30'd70909952;

  typedef struct packed {
    logic signed [DIST_W-1:0] tca;
    logic                     hit_in;
    logic                     hit_out;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SQ_W-1:0]   arg;
  } sqrt_lane_t;

  // one result bit of the digit-by-digit square root
  function automatic sqrt_lane_t sqrt_step(input sqrt_lane_t s);
    sqrt_lane_t       o;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    rem_sh = {s.rem[REM_W-3:0], s.arg[SQ_W-1:SQ_W-2]};
    trial  = {1'b0, s.root, 2'b01};
    if (rem_sh >= trial) begin
      o.rem  = rem_sh - trial;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = rem_sh;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    o.arg = {s.arg[SQ_W-3:0], 2'b00};
    return o;
  endfunction

  function automatic logic signed [DIST_W-1:0] sat_dist(input logic signed [DIFF_W-1:0] v);
    logic signed [DIST_W-1:0] o;
    if (v[DIFF_W-1:DIST_W-1] == '0 || v[DIFF_W-1:DIST_W-1] == '1) begin
      o = v[DIST_W-1:0];
    end else if (v[DIFF_W-1]) begin
      o = {1'b1, {(DIST_W-1){1'b0}}};
    end else begin
      o = {1'b0, {(DIST_W-1){1'b1}}};
    end
    return o;
  endfunction

endpackage

>>> hdl/rsi_front.sv
`timescale 1ns / 1ps
module rsi_front import rsi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [COORD_W-1:0] origin_x,
  input  logic signed [COORD_W-1:0] origin_y,
  input  logic signed [COORD_W-1:0] origin_z,
  input  logic signed [DIR_W-1:0]   dir_x,
  input  logic signed [DIR_W-1:0]   dir_y,
  input  logic signed [DIR_W-1:0]   dir_z,
  input  logic signed [COORD_W-1:0] center_x,
  input  logic signed [COORD_W-1:0] center_y,
  input  logic signed [COORD_W-1:0] center_z,
  input  logic [RAD_W-1:0]          inner_radius,
  input  logic [RAD_W-1:0]          outer_radius,
  output logic                      valid,
  output side_t                     side,
  output logic [SQ_W-1:0]           arg_in,
  output logic [SQ_W-1:0]           arg_out
);

  logic [5:0] v_r;

  logic signed [REL_W-1:0] rx_r, ry_r, rz_r;
  logic signed [DIR_W-1:0] dx_r, dy_r, dz_r;
  logic signed [DOT_W-1:0] px_r, py_r, pz_r;
  logic signed [SQ_W-1:0]  qx_r, qy_r, qz_r;
  logic signed [DOT_W-1:0] dot_r;
  logic [SQ_W-1:0]         rel2_r3, rel2_r4, rel2_r5, rel2_r6;
  logic signed [DIST_W-1:0] tca_r4, tca_r5, tca_r6;
  logic [SQ_W-1:0]         t2_r5;
  logic [SQ_W-1:0]         ai_r, ao_r;
  logic [SQ_W-1:0]         ri2_r, ro2_r;

  logic signed [DOT_W-1:0] dot_sh;
  logic signed [DIST_W-1:0] tca_nxt;
  logic signed [SQ_W-1:0]  t2_s;
  logic                    hit_in_nxt, hit_out_nxt;

  // floor shift, then saturate tca to 32 bits
  always_comb begin
    dot_sh = dot_r >>> FRAC_BITS;
    if (dot_sh[DOT_W-1:DIST_W-1] == '0 || dot_sh[DOT_W-1:DIST_W-1] == '1) begin
      tca_nxt = dot_sh[DIST_W-1:0];
    end else if (dot_sh[DOT_W-1]) begin
      tca_nxt = {1'b1, {(DIST_W-1){1'b0}}};
    end else begin
      tca_nxt = {1'b0, {(DIST_W-1){1'b1}}};
    end
    t2_s        = tca_r4 * tca_r4;
    hit_in_nxt  = ai_r >= rel2_r6;
    hit_out_nxt = ao_r >= rel2_r6;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      valid <= 1'b0;
    end else if (en) begin
      v_r   <= {v_r[4:0], in_valid};
      valid <= v_r[5];
    end
  end

  // radius squares track cfg; users keep it static while items fly, no check
  always_ff @(posedge clk) begin
    ri2_r <= SQ_W'(inner_radius) * SQ_W'(inner_radius);
    ro2_r <= SQ_W'(outer_radius) * SQ_W'(outer_radius);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r <= REL_W'(center_x) - REL_W'(origin_x);
      ry_r <= REL_W'(center_y) - REL_W'(origin_y);
      rz_r <= REL_W'(center_z) - REL_W'(origin_z);
      dx_r <= dir_x;
      dy_r <= dir_y;
      dz_r <= dir_z;

      px_r <= rx_r * dx_r;
      py_r <= ry_r * dy_r;
      pz_r <= rz_r * dz_r;
      qx_r <= rx_r * rx_r;
      qy_r <= ry_r * ry_r;
      qz_r <= rz_r * rz_r;

      dot_r   <= px_r + py_r + pz_r;
      rel2_r3 <= SQ_W'(qx_r) + SQ_W'(qy_r) + SQ_W'(qz_r);

      tca_r4  <= tca_nxt;
      rel2_r4 <= rel2_r3;

      tca_r5  <= tca_r4;
      t2_r5   <= SQ_W'(t2_s);
      rel2_r5 <= rel2_r4;

      tca_r6  <= tca_r5;
      ai_r    <= ri2_r + t2_r5;
      ao_r    <= ro2_r + t2_r5;
      rel2_r6 <= rel2_r5;

      side.tca     <= tca_r6;
      side.hit_in  <= hit_in_nxt;
      side.hit_out <= hit_out_nxt;
      arg_in       <= hit_in_nxt ? ai_r - rel2_r6 : '0;
      arg_out      <= hit_out_nxt ? ao_r - rel2_r6 : '0;
    end
  end

endmodule

>>> hdl/rsi_sqrt.sv
`timescale 1ns / 1ps
module rsi_sqrt import rsi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  side_t             in_side,
  input  logic [SQ_W-1:0]   arg_in,
  input  logic [SQ_W-1:0]   arg_out,
  output logic              valid,
  output side_t             side,
  output logic [ROOT_W-1:0] root_in,
  output logic [ROOT_W-1:0] root_out
);

  logic       v_r    [SQRT_STAGES];
  side_t      side_r [SQRT_STAGES];
  sqrt_lane_t li_r   [SQRT_STAGES];
  sqrt_lane_t lo_r   [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    sqrt_lane_t li_nxt, lo_nxt;
    logic       v_prev;
    side_t      side_prev;

    always_comb begin
      if (s == 0) begin
        li_nxt    = '{rem: '0, root: '0, arg: arg_in};
        lo_nxt    = '{rem: '0, root: '0, arg: arg_out};
        v_prev    = in_valid;
        side_prev = in_side;
      end else begin
        li_nxt    = li_r[(s == 0) ? 0 : s-1];
        lo_nxt    = lo_r[(s == 0) ? 0 : s-1];
        v_prev    = v_r[(s == 0) ? 0 : s-1];
        side_prev = side_r[(s == 0) ? 0 : s-1];
      end
      for (int k = 0; k < SQRT_STEPS_PER_STAGE; k++) begin
        li_nxt = sqrt_step(li_nxt);
        lo_nxt = sqrt_step(lo_nxt);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        li_r[s]   <= li_nxt;
        lo_r[s]   <= lo_nxt;
        side_r[s] <= side_prev;
      end
    end
  end

  assign valid    = v_r[SQRT_STAGES-1];
  assign side     = side_r[SQRT_STAGES-1];
  assign root_in  = li_r[SQRT_STAGES-1].root;
  assign root_out = lo_r[SQRT_STAGES-1].root;

endmodule

>>> hdl/rsi_back.sv
`timescale 1ns / 1ps
module rsi_back import rsi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  side_t                    in_side,
  input  logic [ROOT_W-1:0]        root_in,
  input  logic [ROOT_W-1:0]        root_out,
  output logic                     valid,
  output logic [CNT_W-1:0]         span_count,
  output logic signed [DIST_W-1:0] first_enter,
  output logic signed [DIST_W-1:0] first_leave,
  output logic signed [DIST_W-1:0] second_enter,
  output logic signed [DIST_W-1:0] second_leave
);

  localparam logic signed [DIFF_W-1:0] NEG_ONE = -(DIFF_W'(1) << FRAC_BITS);

  logic                     v_r;
  logic                     hit_in_r, hit_out_r;
  logic signed [DIFF_W-1:0] d0_r, d1_r, d2_r, d3_r;

  logic signed [DIFF_W-1:0] tca_x, hi_x, ho_x;
  logic                     span_a, span_b;
  logic signed [DIFF_W-1:0] s_raw, s_clamp, d0_clamp;
  logic signed [DIFF_W-1:0] fe_nxt, fl_nxt, se_nxt, sl_nxt;

  assign tca_x = DIFF_W'(in_side.tca);
  assign hi_x  = $signed({2'b00, root_in});
  assign ho_x  = $signed({2'b00, root_out});

  always_comb begin
    span_a   = hit_in_r && !d1_r[DIFF_W-1];
    span_b   = hit_out_r && !d3_r[DIFF_W-1];
    s_raw    = hit_in_r ? d2_r : d0_r;
    s_clamp  = s_raw[DIFF_W-1] ? '0 : s_raw;
    d0_clamp = d0_r[DIFF_W-1] ? '0 : d0_r;
    fe_nxt   = NEG_ONE;
    fl_nxt   = NEG_ONE;
    se_nxt   = NEG_ONE;
    sl_nxt   = NEG_ONE;
    priority if (span_a) begin
      fe_nxt = d0_clamp;
      fl_nxt = d1_r;
      if (span_b) begin
        se_nxt = s_clamp;
        sl_nxt = d3_r;
      end
    end else if (span_b) begin
      fe_nxt = s_clamp;
      fl_nxt = d3_r;
    end else begin
      // no span: every slot stays at -1.0
      fe_nxt = NEG_ONE;
      fl_nxt = NEG_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v_r   <= in_valid;
      valid <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_in_r  <= in_side.hit_in;
      hit_out_r <= in_side.hit_out;
      d0_r      <= tca_x - ho_x;
      d1_r      <= tca_x - hi_x;
      d2_r      <= tca_x + hi_x;
      d3_r      <= tca_x + ho_x;

      span_count   <= CNT_W'(span_a) + CNT_W'(span_b);
      first_enter  <= sat_dist(fe_nxt);
      first_leave  <= sat_dist(fl_nxt);
      second_enter <= sat_dist(se_nxt);
      second_leave <= sat_dist(sl_nxt);
    end
  end

endmodule

>>> hdl/ray_shell_interval.sv
`timescale 1ns / 1ps
// Ray against spherical shell: each transaction on the in_ channel carries a ray origin and a
// unit direction (signed fixed point, FRAC_BITS fraction bits) and yields one transaction on
// the out_ channel with up to two distance intervals inside the shell, starts clamped to zero
// and absent slots at -1.0. The block is fully pipelined, one ray per cycle unless out_ is held,
// passing 7 stages of products and sums, 16 stages of a square root that resolves two root bits
// per stage and 2 stages of interval assembly. The whole pipe advances together, so a result held
// on out_ stalls the input. Shell centre and radii are written on the cfg_ channel by register
// index (0..2 centre x/y/z, 3 inner radius, 4 outer radius) and must only change while no ray is
// in flight.
module ray_shell_interval import rsi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_origin_x,
  input  logic signed [COORD_W-1:0] in_origin_y,
  input  logic signed [COORD_W-1:0] in_origin_z,
  input  logic signed [DIR_W-1:0]   in_dir_x,
  input  logic signed [DIR_W-1:0]   in_dir_y,
  input  logic signed [DIR_W-1:0]   in_dir_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CNT_W-1:0]          out_span_count,
  output logic signed [DIST_W-1:0]  out_first_enter,
  output logic signed [DIST_W-1:0]  out_first_leave,
  output logic signed [DIST_W-1:0]  out_second_enter,
  output logic signed [DIST_W-1:0]  out_second_leave,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam logic signed [DIST_W-1:0] NEG_ONE = -(DIST_W'(1) << FRAC_BITS);

  logic signed [COORD_W-1:0] center_x_r, center_y_r, center_z_r;
  logic [RAD_W-1:0]          inner_r_r, outer_r_r;

  logic              en;
  logic              f_valid, s_valid;
  side_t             f_side, s_side;
  logic [SQ_W-1:0]   arg_in, arg_out;
  logic [ROOT_W-1:0] root_in, root_out;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= CENTER_X_RST;
      center_y_r <= CENTER_Y_RST;
      center_z_r <= CENTER_Z_RST;
      inner_r_r  <= INNER_R_RST;
      outer_r_r  <= OUTER_R_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_X: center_x_r <= cfg_data[COORD_W-1:0];
        REG_CENTER_Y: center_y_r <= cfg_data[COORD_W-1:0];
        REG_CENTER_Z: center_z_r <= cfg_data[COORD_W-1:0];
        REG_INNER_R:  inner_r_r  <= cfg_data[RAD_W-1:0];
        REG_OUTER_R:  outer_r_r  <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  rsi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_valid && in_ready),
    .origin_x     (in_origin_x),
    .origin_y     (in_origin_y),
    .origin_z     (in_origin_z),
    .dir_x        (in_dir_x),
    .dir_y        (in_dir_y),
    .dir_z        (in_dir_z),
    .center_x     (center_x_r),
    .center_y     (center_y_r),
    .center_z     (center_z_r),
    .inner_radius (inner_r_r),
    .outer_radius (outer_r_r),
    .valid        (f_valid),
    .side         (f_side),
    .arg_in       (arg_in),
    .arg_out      (arg_out)
  );

  rsi_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (f_valid),
    .in_side  (f_side),
    .arg_in   (arg_in),
    .arg_out  (arg_out),
    .valid    (s_valid),
    .side     (s_side),
    .root_in  (root_in),
    .root_out (root_out)
  );

  rsi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (s_valid),
    .in_side      (s_side),
    .root_in      (root_in),
    .root_out     (root_out),
    .valid        (out_valid),
    .span_count   (out_span_count),
    .first_enter  (out_first_enter),
    .first_leave  (out_first_leave),
    .second_enter (out_second_enter),
    .second_leave (out_second_leave)
  );

  a_no_valid_after_reset: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_span_count != 2'd3)
    else $error("span count out of range");

  a_empty_slots: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_span_count == '0 |->
      out_first_enter == NEG_ONE && out_first_leave == NEG_ONE)
    else $error("first slot filled with no span");

  a_second_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_span_count != 2'd2 |->
      out_second_enter == NEG_ONE && out_second_leave == NEG_ONE)
    else $error("second slot filled without two spans");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rsi_pkg::*;

  localparam int LATENCY = 25;
  localparam int FRAC    = FRAC_BITS_DEF;
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC;
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [COORD_W-1:0] ox, oy, oz;
    logic signed [DIR_W-1:0]   dx, dy, dz;
  } ray_t;

  typedef struct {
    logic [CNT_W-1:0]         count;
    logic signed [DIST_W-1:0] span [4];
  } spans_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [DIR_W-1:0]   in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CNT_W-1:0] out_span_count;
  logic signed [DIST_W-1:0] out_first_enter, out_first_leave;
  logic signed [DIST_W-1:0] out_second_enter, out_second_leave;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow copy of the shell registers
  logic signed [COORD_W-1:0] shell_cx = CENTER_X_RST;
  logic signed [COORD_W-1:0] shell_cy = CENTER_Y_RST;
  logic signed [COORD_W-1:0] shell_cz = CENTER_Z_RST;
  logic [RAD_W-1:0] shell_rin  = INNER_R_RST;
  logic [RAD_W-1:0] shell_rout = OUTER_R_RST;

  spans_t expected_spans[$];
  int errors = 0;
  int hold_off = 0;
  int gap_max = 3;

  ray_shell_interval dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [63:0] floor_root(input logic [63:0] a);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic spans_t shell_spans(input ray_t r);
    logic signed [63:0] rx, ry, rz, dx, dy, dz, tca, hi, ho, d0, d1, d2, d3, s;
    logic signed [63:0] slot [4];
    logic [63:0] rel2, t2, rin, rout, ai, ao;
    logic hit_in, hit_out;
    int cnt;
    spans_t o;
    rx = shell_cx; rx = rx - r.ox;
    ry = shell_cy; ry = ry - r.oy;
    rz = shell_cz; rz = rz - r.oz;
    dx = r.dx; dy = r.dy; dz = r.dz;
    tca = clamp32((rx * dx + ry * dy + rz * dz) >>> FRAC);
    rel2 = rx * rx + ry * ry + rz * rz;
    t2 = tca * tca;
    rin = shell_rin;
    rout = shell_rout;
    ai = rin * rin + t2;
    ao = rout * rout + t2;
    hit_in = ai >= rel2;
    hit_out = ao >= rel2;
    hi = floor_root(hit_in ? ai - rel2 : 64'd0);
    ho = floor_root(hit_out ? ao - rel2 : 64'd0);
    d0 = tca - ho; d1 = tca - hi; d2 = tca + hi; d3 = tca + ho;
    for (int k = 0; k < 4; k++) slot[k] = -ONE;
    cnt = 0;
    if (hit_in && d1 >= 0) begin
      slot[0] = d0 > 0 ? d0 : 64'sd0;
      slot[1] = d1;
      cnt = 1;
    end
    if (hit_out && d3 >= 0) begin
      s = hit_in ? d2 : d0;
      slot[cnt*2] = s > 0 ? s : 64'sd0;
      slot[cnt*2+1] = d3;
      cnt++;
    end
    o.count = cnt[CNT_W-1:0];
    for (int k = 0; k < 4; k++) o.span[k] = clamp32(slot[k]);
    return o;
  endfunction

  task automatic compare_field(input string name, input logic [DIST_W-1:0] want,
                               input logic [DIST_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, $signed(want), $signed(got));
      errors++;
    end
  endtask

  // result side, checked; random stalls, long hold-offs at random or on request
  always @(posedge clk) begin
    spans_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_spans.size() == 0) begin
        $display("%0t: unexpected result transaction, count %0d", $time, out_span_count);
        errors++;
      end else begin
        e = expected_spans.pop_front();
        compare_field("span_count", 32'(e.count), 32'(out_span_count));
        compare_field("first_enter", e.span[0], out_first_enter);
        compare_field("first_leave", e.span[1], out_first_leave);
        compare_field("second_enter", e.span[2], out_second_enter);
        compare_field("second_leave", e.span[3], out_second_leave);
      end
    end
    if (hold_off > 0) begin
      hold_off--;
      out_ready <= 1'b0;
    end else if (gap_max == 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) < 12) ? 1'b0 : 1'b1;
      if ($urandom_range(0, 199) == 0) hold_off = $urandom_range(20, 80);
    end
  end

  task automatic send_ray(input ray_t r);
    int gap;
    gap = (gap_max == 0) ? 0 :
          ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_origin_x <= r.ox; in_origin_y <= r.oy; in_origin_z <= r.oz;
    in_dir_x <= r.dx; in_dir_y <= r.dy; in_dir_z <= r.dz;
    do @(posedge clk); while (!in_ready);
    expected_spans.push_back(shell_spans(r));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_spans.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CENTER_X: shell_cx = v[COORD_W-1:0];
      REG_CENTER_Y: shell_cy = v[COORD_W-1:0];
      REG_CENTER_Z: shell_cz = v[COORD_W-1:0];
      REG_INNER_R:  shell_rin = v[RAD_W-1:0];
      REG_OUTER_R:  shell_rout = v[RAD_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_shell(input logic signed [COORD_W-1:0] cx, cy, cz,
                           input logic [RAD_W-1:0] rin, rout);
    write_reg(REG_CENTER_X, {$urandom_range(0, 1) == 1, cx});
    write_reg(REG_CENTER_Y, {$urandom_range(0, 1) == 1, cy});
    write_reg(REG_CENTER_Z, {$urandom_range(0, 1) == 1, cz});
    write_reg(REG_INNER_R, {2'($urandom()), rin});
    write_reg(REG_OUTER_R, {2'($urandom()), rout});
  endtask

  function automatic logic signed [COORD_W-1:0] any_coord();
    return COORD_W'($urandom());
  endfunction

  function automatic logic signed [COORD_W-1:0] near(input logic signed [COORD_W-1:0] c,
                                                     input int span);
    logic signed [63:0] v;
    v = c;
    v = v + $signed($urandom_range(0, 2 * span)) - span;
    return COORD_W'(clamp32(v) > 64'sd1073741823 ? 64'sd1073741823 :
                    clamp32(v) < -64'sd1073741824 ? -64'sd1073741824 : v);
  endfunction

  function automatic logic signed [DIR_W-1:0] any_dir();
    return DIR_W'($signed($urandom_range(0, 131072)) - 65536);
  endfunction

  function automatic ray_t mk(input logic signed [COORD_W-1:0] ox, oy, oz,
                              input logic signed [DIR_W-1:0] dx, dy, dz);
    ray_t r;
    r.ox = ox; r.oy = oy; r.oz = oz; r.dx = dx; r.dy = dy; r.dz = dz;
    return r;
  endfunction

  // origin near the shell centre and a random unit direction
  function automatic ray_t aimed_ray(input int span);
    ray_t r;
    logic signed [63:0] v [3];
    logic [63:0] len;
    r.ox = near(shell_cx, span); r.oy = near(shell_cy, span); r.oz = near(shell_cz, span);
    v[0] = $signed($urandom_range(0, 2000)) - 1000;
    v[1] = $signed($urandom_range(0, 2000)) - 1000;
    v[2] = $signed($urandom_range(0, 2000)) - 1000;
    len = floor_root(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
    if (len == 0) begin
      v[0] = 1;
      len = 1;
    end
    r.dx = DIR_W'((v[0] <<< FRAC) / $signed(len));
    r.dy = DIR_W'((v[1] <<< FRAC) / $signed(len));
    r.dz = DIR_W'((v[2] <<< FRAC) / $signed(len));
    return r;
  endfunction

  task automatic test_default_shell;
    send_ray(mk(0, 0, 0, 0, DIR_W'(65536), 0));
    send_ray(mk(0, 0, 0, 0, DIR_W'(-65536), 0));
    send_ray(mk(0, 0, 0, DIR_W'(65536), 0, 0));
    send_ray(mk(0, 0, 0, 0, 0, DIR_W'(-65536)));
    // origin beyond the outer sphere, pointing away: no span ahead of the origin
    send_ray(mk(0, 31'sd536870912, 0, 0, DIR_W'(65536), 0));
    // pointing back through the whole shell
    send_ray(mk(0, 31'sd536870912, 0, 0, DIR_W'(-65536), 0));
    // grazing only the outer sphere
    send_ray(mk(31'sd69500000, 31'sd536870912, 0, 0, DIR_W'(-65536), 0));
    send_ray(mk(0, 0, 0, 0, 0, 0));
    send_ray(mk(0, 0, 0, DIR_W'(65536), DIR_W'(65536), DIR_W'(-65536)));
    send_ray(mk(31'sh3fffffff, 31'sh3fffffff, 31'sh3fffffff,
                DIR_W'(-65536), DIR_W'(-65536), DIR_W'(-65536)));
    send_ray(mk(-31'sd1073741824, -31'sd1073741824, -31'sd1073741824,
                DIR_W'(65536), DIR_W'(65536), DIR_W'(65536)));
    send_ray(mk(-31'sd1073741824, 31'sh3fffffff, -31'sd1073741824,
                DIR_W'(-65536), DIR_W'(65536), DIR_W'(-65536)));
    drain();
  endtask

  task automatic test_extreme_shells;
    // far centre and far origin: tca and distances saturate
    set_shell(31'sh3fffffff, 31'sh3fffffff, 31'sh3fffffff, 30'h3fffffff, 30'h3fffffff);
    send_ray(mk(-31'sd1073741824, -31'sd1073741824, -31'sd1073741824,
                DIR_W'(65536), DIR_W'(65536), DIR_W'(65536)));
    send_ray(mk(-31'sd1073741824, -31'sd1073741824, -31'sd1073741824,
                DIR_W'(-65536), DIR_W'(-65536), DIR_W'(-65536)));
    send_ray(mk(0, 0, 0, DIR_W'(65536), 0, 0));
    drain();
    set_shell(-31'sd1073741824, -31'sd1073741824, -31'sd1073741824, '0, '0);
    send_ray(mk(-31'sd1073741824, -31'sd1073741824, -31'sd1073741824, DIR_W'(65536), 0, 0));
    send_ray(mk(31'sh3fffffff, 31'sh3fffffff, 31'sh3fffffff,
                DIR_W'(-65536), DIR_W'(-65536), DIR_W'(-65536)));
    drain();
    // outer radius below inner
    set_shell(0, 0, 0, 30'd6553600, 30'd3276800);
    send_ray(mk(-31'sd13107200, 0, 0, DIR_W'(65536), 0, 0));
    send_ray(mk(0, 0, 0, 0, DIR_W'(65536), 0));
    drain();
    // indexes past the register list must be ignored
    for (int i = REG_OUTER_R + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), 32'($urandom()));
    send_ray(mk(0, 0, 0, 0, DIR_W'(-65536), 0));
    drain();
  endtask

  task automatic test_random(input int n, input int span);
    ray_t r;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: r = mk(any_coord(), any_coord(), any_coord(), any_dir(), any_dir(), any_dir());
        1: begin
          r = aimed_ray(span);
          r.dx = any_dir();
        end
        default: r = aimed_ray(span);
      endcase
      send_ray(r);
    end
    drain();
  endtask

  task automatic test_backpressure;
    gap_max = 0;
    hold_off = 300;
    test_random(120, 1 << 26);
    gap_max = 3;
  endtask

  task automatic test_shell_settings;
    logic [RAD_W-1:0] a, b;
    for (int p = 0; p < 12; p++) begin
      a = $urandom_range(0, (p < 9) ? (1 << 27) : 30'h3fffffff);
      b = (p == 5) ? a - $urandom_range(0, 1000) : a + $urandom_range(0, 1 << 24);
      set_shell(near(0, 1 << 28), near(0, 1 << 28), near(0, 1 << 28), a, b);
      test_random(140, (p < 9) ? (1 << 27) : (1 << 30));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_shell();
    test_random(100, 1 << 27);
    test_extreme_shells();
    test_backpressure();
    test_shell_settings();
    drain();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
